>>> sv/newton_square_root_unit_macros.svh
// Assertion macros for the checker file of the square root unit.
// Each macro samples on clk_i and is quiet while rst_ni is low.
`ifndef NEWTON_SQUARE_ROOT_UNIT_MACROS_SVH
`define NEWTON_SQUARE_ROOT_UNIT_MACROS_SVH

// Same-cycle implication
`define NSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define NSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/nsr_pkg.sv
package nsr_pkg;

  // Default number formats
  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned VALUE_WIDTH_DEF   = 32;

  // Register file
  localparam int unsigned TOL_W      = 32;
  localparam int unsigned ITER_W     = 7;
  localparam int unsigned STEPS_W    = 7;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [TOL_W-1:0]  TOL_RESET   = 32'd42950;
  localparam logic [ITER_W-1:0] ITER_RESET  = 7'd32;
  localparam logic [ITER_W-1:0] ITER_LIMIT  = 7'd64;

  // Register index, taken from paddr[2]
  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_MAX_ITER  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_CMP,
    ST_DONE
  } nsr_state_e;

endpackage

>>> sv/nsr_div.sv
module nsr_div #(
  parameter int unsigned W = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     quo_q, quo_d;
  logic [W-1:0]     den_q, den_d;

  logic [W:0]       rem_sh;
  logic [W+1:0]     trial;
  logic             fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem_q, quo_q[W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_q};
  assign fits   = ~trial[W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(W);
      rem_d  = '0;
      quo_d  = num_i;
      // Treat a zero divisor as one
      den_d  = (den_i == '0) ? W'(1) : den_i;
    end else if (busy_q) begin
      rem_d = fits ? trial[W-1:0] : rem_sh[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> sv/newton_square_root_unit.sv
// Sequence: a zero radicand goes straight to the result; otherwise each Newton step runs
// the radix-2 divider over NUM_W = VALUE_WIDTH + FRACTION_BITS bits, one bit a cycle,
// then the update, two partial products, accumulate and compare states.
// Throughput: one item at a time; s_axis_tready is high only while the sequencer idles.
// Reset (rst_ni low, asynchronous): sequencer idle, no result pending, registers
// back to tolerance_q32 = 42950 and max_iterations = 32.
module newton_square_root_unit #(
  parameter int unsigned FRACTION_BITS = nsr_pkg::FRACTION_BITS_DEF,
  parameter int unsigned VALUE_WIDTH   = nsr_pkg::VALUE_WIDTH_DEF,
  localparam int unsigned NUM_W        = VALUE_WIDTH + FRACTION_BITS,
  localparam int unsigned ROOT_W       = NUM_W / 2,
  localparam int unsigned IN_TDATA_W   = ((VALUE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_TDATA_W  = ((ROOT_W + nsr_pkg::STEPS_W + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [IN_TDATA_W-1:0]             s_axis_tdata,   // x_value
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [OUT_TDATA_W-1:0]            m_axis_tdata,   // root, steps_used
  output logic                              m_axis_tuser,   // not_converged
  // Register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nsr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [nsr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [nsr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int unsigned HALF  = (NUM_W + 1) / 2;
  localparam int unsigned HI_W  = NUM_W - HALF;
  localparam int unsigned TOL_W = nsr_pkg::TOL_W;
  localparam int unsigned PRD_W = TOL_W + NUM_W;

  nsr_pkg::nsr_state_e state_q, state_d;

  logic [TOL_W-1:0]            tol_q;
  logic [nsr_pkg::ITER_W-1:0]  max_iter_q;
  logic [nsr_pkg::ITER_W-1:0]  cap_q, cap_c;
  logic [nsr_pkg::STEPS_W-1:0] steps_q, steps_nxt;
  logic                        unconv_q;

  logic [NUM_W-1:0]            num_q;
  logic [NUM_W-1:0]            y_q;
  logic [NUM_W-1:0]            ynew_q, ynew_c;
  logic [NUM_W-1:0]            diff_q;
  logic [PRD_W-1:0]            pp_q;
  logic [PRD_W-1:0]            prod_q;

  logic                        m_valid_q;
  logic [ROOT_W-1:0]           out_root_q;
  logic [nsr_pkg::STEPS_W-1:0] out_steps_q;
  logic                        out_nc_q;

  logic [VALUE_WIDTH-1:0]      x_in;
  logic                        in_xfer;
  logic                        cfg_wr;
  logic                        div_start;
  logic                        div_done;
  logic [NUM_W-1:0]            div_quo;
  logic [NUM_W-1:0]            div_den;
  logic [PRD_W-1:0]            lhs;
  logic                        tol_met;
  logic                        cap_hit;
  logic                        out_free;
  logic                        root_sat;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q      <= nsr_pkg::TOL_RESET;
      max_iter_q <= nsr_pkg::ITER_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        nsr_pkg::REG_TOLERANCE: tol_q      <= pwdata[TOL_W-1:0];
        nsr_pkg::REG_MAX_ITER:  max_iter_q <= pwdata[nsr_pkg::ITER_W-1:0];
        default:                tol_q      <= tol_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      nsr_pkg::REG_TOLERANCE: prdata = nsr_pkg::APB_DATA_W'(tol_q);
      nsr_pkg::REG_MAX_ITER:  prdata = nsr_pkg::APB_DATA_W'(max_iter_q);
      default:                prdata = '0;
    endcase
  end

  // Input side
  assign x_in          = s_axis_tdata[VALUE_WIDTH-1:0];
  assign s_axis_tready = (state_q == nsr_pkg::ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  // Clamp the step cap into 1..64
  always_comb begin
    priority if (max_iter_q == '0)                 cap_c = nsr_pkg::ITER_W'(1);
    else if (max_iter_q > nsr_pkg::ITER_LIMIT)     cap_c = nsr_pkg::ITER_LIMIT;
    else                                           cap_c = max_iter_q;
  end

  // Shared divider: num / y, one quotient bit a cycle
  assign div_den = (state_q == nsr_pkg::ST_IDLE) ? NUM_W'(1) << FRACTION_BITS : ynew_q;

  nsr_div #(
    .W (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ((state_q == nsr_pkg::ST_IDLE) ? (NUM_W'(x_in) << FRACTION_BITS) : num_q),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Newton update and stop test
  assign ynew_c    = (y_q >> 1) + (div_quo >> 1) + NUM_W'(y_q[0] & div_quo[0]);
  assign lhs       = {diff_q, {TOL_W{1'b0}}};
  assign tol_met   = (lhs < prod_q);
  assign steps_nxt = steps_q + nsr_pkg::STEPS_W'(1);
  assign cap_hit   = (steps_nxt >= cap_q);
  assign out_free  = ~m_valid_q | m_axis_tready;
  assign root_sat  = |y_q[NUM_W-1:ROOT_W];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nsr_pkg::ST_IDLE: begin
        if (in_xfer) state_d = (x_in == '0) ? nsr_pkg::ST_DONE : nsr_pkg::ST_DIV;
      end
      nsr_pkg::ST_DIV:    if (div_done) state_d = nsr_pkg::ST_UPD;
      nsr_pkg::ST_UPD:    state_d = nsr_pkg::ST_MUL_LO;
      nsr_pkg::ST_MUL_LO: state_d = nsr_pkg::ST_MUL_HI;
      nsr_pkg::ST_MUL_HI: state_d = nsr_pkg::ST_ACC;
      nsr_pkg::ST_ACC:    state_d = nsr_pkg::ST_CMP;
      nsr_pkg::ST_CMP:    state_d = (tol_met | cap_hit) ? nsr_pkg::ST_DONE : nsr_pkg::ST_DIV;
      nsr_pkg::ST_DONE:   if (out_free) state_d = nsr_pkg::ST_IDLE;
      default:            state_d = nsr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    div_start = 1'b0;
    unique case (state_q)
      nsr_pkg::ST_IDLE: div_start = in_xfer & (x_in != '0);
      nsr_pkg::ST_CMP:  div_start = ~(tol_met | cap_hit);
      default:          div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nsr_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == nsr_pkg::ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      nsr_pkg::ST_IDLE: begin
        num_q    <= NUM_W'(x_in) << FRACTION_BITS;
        y_q      <= (x_in == '0) ? '0 : (NUM_W'(1) << FRACTION_BITS);
        ynew_q   <= NUM_W'(1) << FRACTION_BITS;
        steps_q  <= '0;
        unconv_q <= 1'b0;
        cap_q    <= cap_c;
      end
      nsr_pkg::ST_UPD: begin
        ynew_q <= ynew_c;
        diff_q <= (y_q > ynew_c) ? (y_q - ynew_c) : (ynew_c - y_q);
      end
      // Tolerance times old estimate, in two partial products
      nsr_pkg::ST_MUL_LO: pp_q <= PRD_W'(tol_q * y_q[HALF-1:0]);
      nsr_pkg::ST_MUL_HI: begin
        prod_q <= pp_q;
        pp_q   <= PRD_W'(tol_q * y_q[NUM_W-1 -: HI_W]);
      end
      nsr_pkg::ST_ACC: prod_q <= prod_q + (pp_q << HALF);
      nsr_pkg::ST_CMP: begin
        y_q      <= ynew_q;
        steps_q  <= steps_nxt;
        unconv_q <= ~tol_met & cap_hit;
      end
      default: y_q <= y_q;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (state_q == nsr_pkg::ST_DONE && out_free) begin
      out_root_q  <= root_sat ? {ROOT_W{1'b1}} : y_q[ROOT_W-1:0];
      out_steps_q <= steps_q;
      out_nc_q    <= unconv_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_steps_q, out_root_q});
  assign m_axis_tuser  = out_nc_q;

endmodule

>>> sv/nsr_checker.sv
`include "newton_square_root_unit_macros.svh"

module nsr_checker #(
  parameter int unsigned FRACTION_BITS = nsr_pkg::FRACTION_BITS_DEF,
  parameter int unsigned VALUE_WIDTH   = nsr_pkg::VALUE_WIDTH_DEF,
  localparam int unsigned NUM_W        = VALUE_WIDTH + FRACTION_BITS,
  localparam int unsigned ROOT_W       = NUM_W / 2,
  localparam int unsigned OUT_TDATA_W  = ((ROOT_W + nsr_pkg::STEPS_W + 7) / 8) * 8
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  logic [nsr_pkg::STEPS_W-1:0] steps;
  logic [ROOT_W-1:0]           root;

  assign steps = m_axis_tdata[ROOT_W +: nsr_pkg::STEPS_W];
  assign root  = m_axis_tdata[ROOT_W-1:0];

  // A stalled result keeps its value
  `NSR_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // One item at a time: the input closes after a transfer
  `NSR_ASSERT_NXT(a_in_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input open while working")

  // Step count stays within the cap limit
  `NSR_ASSERT_IMP(a_steps_max, m_axis_tvalid, steps <= nsr_pkg::ITER_LIMIT, "step count above limit")

  // Not converged implies at least one step
  `NSR_ASSERT_IMP(a_nc_steps, m_axis_tvalid && m_axis_tuser, steps != '0, "not converged with no steps")

  // No steps only for a zero radicand, which gives a zero root
  `NSR_ASSERT_IMP(a_zero_root, m_axis_tvalid && steps == '0, root == '0 && !m_axis_tuser, "zero steps with nonzero root")

endmodule

bind newton_square_root_unit nsr_checker #(
  .FRACTION_BITS (FRACTION_BITS),
  .VALUE_WIDTH   (VALUE_WIDTH)
) u_nsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
